@@ sv/fsia_pkg.sv @@
// Shared constants and helpers for the integer-to-ASCII stream formatter.
// Used by fsia_dabble and format_stream_int_to_ascii; no dependencies.
package fsia_pkg;

  localparam int unsigned BIN_W      = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned CNT_W      = 31;
  localparam int unsigned IN_W       = 40;
  localparam int unsigned OUT_W      = 40;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_X       = 8'h78;

  function automatic logic [7:0] digit_char(input logic [3:0] dig);
    logic [7:0] res;
    if (dig < 4'd10) begin
      res = CH_ZERO + {4'd0, dig};
    end else begin
      res = CH_LOWER_A + {4'd0, dig} - 8'd10;
    end
    return res;
  endfunction

endpackage

@@ sv/fsia_dabble.sv @@
// Bit-serial binary to BCD converter using the shift-and-add-three method.
// One input bit per cycle; depends on fsia_pkg.
module fsia_dabble (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fsia_pkg::BIN_W-1:0] bin_i,
  output logic                       done_o,
  output logic [fsia_pkg::BCD_W-1:0] bcd_o
);
  import fsia_pkg::*;

  localparam int unsigned CW = $clog2(BIN_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [BIN_W-1:0] sh_q, sh_d;
  logic [BCD_W-1:0] bcd_q, bcd_d, adj;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] > 4'd4) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(BIN_W - 1);
      sh_d   = bin_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BCD_W-2:0], sh_q[BIN_W-1]};
      sh_d  = {sh_q[BIN_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("converter done while still busy");
  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("converter restarted while busy");
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q))
    else $error("converter done without a run");
`endif

endmodule

@@ sv/format_stream_int_to_ascii.sv @@
// An echoed byte passes through ST_ECHO into the output register; 'x' steps the shifter once
// per digit position (ten); 'd' first runs the bit-serial BCD conversion in ST_CONV, then
// ST_SIGN for a minus sign, then the digits; a '%', a terminator or an unknown letter is
// handled in the idle state and sends nothing out.
// One item is in work at a time; the output register lets a finished beat wait for the sink.
// Reset is asynchronous and active low; it clears the pending flag and the written count.
// Top level of the formatter; depends on fsia_pkg and fsia_dabble.
module format_stream_int_to_ascii (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0: format_byte[7:0], arg_value[39:8].
  input  logic [fsia_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // Fields from bit 0: out_char[7:0], total_written[38:8], zero fill[39].
  output logic [fsia_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                       m_axis_tlast
);
  import fsia_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ECHO, ST_CONV, ST_SIGN, ST_DIGITS
  } state_e;

  state_e           state_q, state_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] written_q, written_d, cnt_inc;
  logic [7:0]       echo_q, echo_d;
  logic             neg_q, neg_d;
  logic [BCD_W-1:0] buf_q, buf_d;
  logic [3:0]       rem_q, rem_d;
  logic             lead_q, lead_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q, out_char_d;
  logic             out_last_q, out_last_d;
  logic [CNT_W-1:0] out_total_q, out_total_d;

  logic             acc, fire, dab_start, dab_done;
  logic [7:0]       in_byte;
  logic [BIN_W-1:0] in_arg, dab_bin;
  logic [BCD_W-1:0] dab_bcd;
  logic [3:0]       dig;

  assign in_byte = s_axis_tdata[7:0];
  assign in_arg  = s_axis_tdata[39:8];
  assign dab_bin = in_arg[BIN_W-1] ? (~in_arg + 1'b1) : in_arg;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign fire = !out_valid_q || m_axis_tready;
  assign cnt_inc = (written_q == COUNT_MAX) ? written_q : written_q + 1'b1;
  assign dig = buf_q[BCD_W-1 -: 4];

  fsia_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .bin_i   (dab_bin),
    .done_o  (dab_done),
    .bcd_o   (dab_bcd)
  );

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    written_d   = written_q;
    echo_d      = echo_q;
    neg_d       = neg_q;
    buf_d       = buf_q;
    rem_d       = rem_q;
    lead_d      = lead_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_total_d = out_total_q;
    dab_start   = 1'b0;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_byte == CH_NUL) begin
            pend_d    = 1'b0;
            written_d = '0;
          end else if (pend_q) begin
            pend_d = 1'b0;
            if (in_byte == CH_D) begin
              dab_start = 1'b1;
              neg_d     = in_arg[BIN_W-1];
              state_d   = ST_CONV;
            end else if (in_byte == CH_X) begin
              buf_d   = {{(BCD_W-BIN_W){1'b0}}, in_arg};
              rem_d   = 4'(BCD_DIGITS);
              lead_d  = 1'b1;
              state_d = ST_DIGITS;
            end
          end else if (in_byte == CH_PERCENT) begin
            pend_d = 1'b1;
          end else begin
            echo_d  = in_byte;
            state_d = ST_ECHO;
          end
        end
      end
      ST_ECHO: begin
        if (fire) begin
          out_valid_d = 1'b1;
          out_char_d  = echo_q;
          out_last_d  = 1'b1;
          out_total_d = cnt_inc;
          written_d   = cnt_inc;
          state_d     = ST_IDLE;
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          buf_d   = dab_bcd;
          rem_d   = 4'(BCD_DIGITS);
          lead_d  = 1'b1;
          state_d = neg_q ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (fire) begin
          out_valid_d = 1'b1;
          out_char_d  = CH_MINUS;
          out_last_d  = 1'b0;
          out_total_d = cnt_inc;
          written_d   = cnt_inc;
          state_d     = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (lead_q && dig == 4'd0 && rem_q != 4'd1) begin
          buf_d = {buf_q[BCD_W-5:0], 4'd0};
          rem_d = rem_q - 1'b1;
        end else if (fire) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(dig);
          out_last_d  = (rem_q == 4'd1);
          out_total_d = cnt_inc;
          written_d   = cnt_inc;
          buf_d       = {buf_q[BCD_W-5:0], 4'd0};
          rem_d       = rem_q - 1'b1;
          lead_d      = 1'b0;
          if (rem_q == 4'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      written_q   <= '0;
      out_valid_q <= 1'b0;
      lead_q      <= 1'b0;
      rem_q       <= '0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      written_q   <= written_d;
      out_valid_q <= out_valid_d;
      lead_q      <= lead_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    echo_q      <= echo_d;
    neg_q       <= neg_d;
    buf_q       <= buf_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_total_q <= out_total_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_total_q, out_char_q};

`ifndef SYNTHESIS
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dab_done |-> state_q == ST_CONV)
    else $error("conversion finished outside the conversion state");
  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGITS |-> rem_q != 4'd0)
    else $error("digit shifter ran out of positions");
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> state_q != ST_IDLE)
    else $error("non-final beat shown with no characters pending");
  a_count_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    written_q < $past(written_q) |-> $past(acc && in_byte == CH_NUL))
    else $error("written count fell without a terminator");
`endif

endmodule
